>>> rtl/core/bfmt_pkg.sv
// Shared types and constants for the bloom filter mark/test block.
// Used by the controller, the datapath and the top level. No dependencies.
package bfmt_pkg;

	localparam logic [1:0] ACT_MARK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// 64-bit multiplicative hash constant, split in 32-bit halves
	localparam logic [31:0] HASH_MULT_LO = 32'hfffc0001;
	localparam logic [31:0] HASH_MULT_HI = 32'h9e37ffff;
	localparam int          HASH_SHIFT   = 18;

	localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
	localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

	localparam int NUM_PROBES     = 6;
	localparam int PROBE_CNT_W    = 3;
	localparam int MIN_SIZE_SHIFT = 10;
	localparam int ROW_SHIFT      = 6;	// 64 filter bits per memory row

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_MIX,
		S_RD,
		S_WR,
		S_CLR,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_BL_ML,
		MUL_BL_MH,
		MUL_BH_ML,
		MUL_MIX1,
		MUL_MIX2
	} mul_sel_t;

	typedef struct packed {
		logic     ready;
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     save_lo;
		logic     save_cross;
		logic     set_h1;
		logic     set_h2;
		logic     probe_wr;
		logic     sweep;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic probe_last;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/bfmt_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bfmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/core/bfmt_ctrl.sv
// Sequencer for the bloom filter: hash steps, probe read/write pairs, clear sweep.
// Depends on bfmt_pkg; drives the datapath through cmd_t, watches status_t.
module bfmt_ctrl import bfmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_action,
	input  status_t    status,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (status.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_action == ACT_CLEAR) ? S_CLR : S_MUL0;
				end
			end
			S_MUL0: state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_MUL4;
			S_MUL4: state_d = S_MIX;
			S_MIX:  state_d = S_RD;
			S_RD:   state_d = S_WR;
			S_WR: begin
				state_d = status.probe_last ? S_DONE : S_RD;
			end
			S_CLR: begin
				if (status.sweep_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_BL_ML;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.load  = in_valid;
			end
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BL_ML;
			end
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BL_MH;
				cmd.save_lo = 1'b1;
			end
			S_MUL2: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_BH_ML;
				cmd.save_cross = 1'b1;
			end
			S_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MIX1;
				cmd.set_h1  = 1'b1;
			end
			S_MUL4: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MIX2;
			end
			S_MIX:  cmd.set_h2   = 1'b1;
			S_WR:   cmd.probe_wr = 1'b1;
			S_INIT: cmd.sweep    = 1'b1;
			S_CLR:  cmd.sweep    = 1'b1;
			S_DONE: cmd.emit     = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/core/bfmt_dp.sv
// Datapath: hash unit on one shared 32x32 multiplier, probe stepping, filter RAM,
// mark counter, size register and output register. Depends on bfmt_pkg, bfmt_ram.
module bfmt_dp import bfmt_pkg::*; #(
	parameter int MAX_SIZE_SHIFT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [1:0]  in_action,
	input  logic [63:0] in_block,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_was,
	output logic [31:0] out_count
);

	localparam int P     = MAX_SIZE_SHIFT;
	localparam int R     = P - ROW_SHIFT;
	localparam int ROWS  = 1 << R;
	localparam int ROW_W = 1 << ROW_SHIFT;
	localparam int LO_W  = HASH_SHIFT + 32;
	localparam logic [4:0] MAX5 = 5'(MAX_SIZE_SHIFT);
	localparam logic [4:0] MIN5 = 5'(MIN_SIZE_SHIFT);

	logic [4:0]             size_q;
	logic [1:0]             action_q;
	logic [63:0]            blk_q;
	logic [63:0]            prod_q;
	logic [LO_W-1:0]        lo_q;
	logic [HASH_SHIFT-1:0]  cross_q;
	logic [P-1:0]           h1_q, h2_q;
	logic [PROBE_CNT_W-1:0] idx_q;
	logic                   all_q;
	logic [R-1:0]           sweep_q;
	logic [31:0]            cnt_q, cnt_d;
	logic                   out_valid_q, out_was_q;
	logic [31:0]            out_cnt_q;

	logic [4:0]            eff_shift;
	logic [P-1:0]          mask;
	logic [31:0]           mul_a, mul_b;
	logic [63:0]           prod_d;
	logic [31:0]           mix_in, mix_mid, mix_out;
	logic [HASH_SHIFT-1:0] cross_sum;
	logic [LO_W-1:0]       h1_sum;
	logic [P-1:0]          h1_new;
	logic                  is_mark;

	logic                  ram_we;
	logic [R-1:0]          ram_addr;
	logic [ROW_W-1:0]      ram_wdata, ram_rdata;
	logic [ROW_SHIFT-1:0]  bit_off;

	always_comb begin
		if (size_q < MIN5) begin
			eff_shift = MIN5;
		end else if (size_q > MAX5) begin
			eff_shift = MAX5;
		end else begin
			eff_shift = size_q;
		end
	end
	assign mask = ~({P{1'b1}} << eff_shift);

	assign mix_in  = blk_q[31:0] ^ (blk_q[31:0] >> 16);
	assign mix_mid = prod_q[31:0] ^ (prod_q[31:0] >> 13);
	assign mix_out = prod_q[31:0] ^ (prod_q[31:0] >> 16);

	always_comb begin
		case (cmd.mul_sel)
			MUL_BL_ML: begin mul_a = blk_q[31:0];  mul_b = HASH_MULT_LO; end
			MUL_BL_MH: begin mul_a = blk_q[31:0];  mul_b = HASH_MULT_HI; end
			MUL_BH_ML: begin mul_a = blk_q[63:32]; mul_b = HASH_MULT_LO; end
			MUL_MIX1:  begin mul_a = mix_in;       mul_b = MIX_C1;       end
			MUL_MIX2:  begin mul_a = mix_mid;      mul_b = MIX_C2;       end
			default:   begin mul_a = '0;           mul_b = '0;           end
		endcase
	end
	assign prod_d = {32'd0, mul_a} * {32'd0, mul_b};

	// only the cross-term bits that land below bit LO_W matter
	assign cross_sum = cross_q + prod_q[HASH_SHIFT-1:0];
	assign h1_sum    = lo_q + {cross_sum, 32'd0};
	assign h1_new    = h1_sum[HASH_SHIFT +: P] & mask;

	assign is_mark   = (action_q == ACT_MARK);
	assign bit_off   = h1_q[ROW_SHIFT-1:0];
	assign ram_addr  = cmd.sweep ? sweep_q : h1_q[P-1:ROW_SHIFT];
	assign ram_we    = cmd.sweep | (cmd.probe_wr & is_mark);
	assign ram_wdata = cmd.sweep ? '0 : (ram_rdata | (ROW_W'(1) << bit_off));

	bfmt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (action_q == ACT_CLEAR) begin
			cnt_d = '0;
		end else if (is_mark) begin
			cnt_d = cnt_q + 32'd1;
		end else begin
			cnt_d = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= MIN5;
			cnt_q       <= '0;
			sweep_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) size_q <= cfg_wdata;
			if (cmd.sweep) sweep_q <= sweep_q + R'(1);
			if (cmd.set_h2) begin
				idx_q <= PROBE_CNT_W'(1);
			end else if (cmd.probe_wr) begin
				idx_q <= idx_q + PROBE_CNT_W'(1);
			end
			if (cmd.emit) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			blk_q    <= in_block;
			all_q    <= 1'b1;
		end
		if (cmd.mul_en)     prod_q  <= prod_d;
		if (cmd.save_lo)    lo_q    <= prod_q[LO_W-1:0];
		if (cmd.save_cross) cross_q <= prod_q[HASH_SHIFT-1:0];
		if (cmd.set_h1)     h1_q    <= h1_new;
		if (cmd.set_h2)     h2_q    <= mix_out[P-1:0] & mask;
		if (cmd.probe_wr) begin
			all_q <= all_q & ram_rdata[bit_off];
			h1_q  <= (h1_q + h2_q) & mask;
			h2_q  <= (h2_q + P'(idx_q)) & mask;
		end
		if (cmd.emit) begin
			out_was_q <= (action_q == ACT_CLEAR) ? 1'b0 : all_q;
			out_cnt_q <= cnt_d;
		end
	end

	assign status.probe_last = (idx_q == PROBE_CNT_W'(NUM_PROBES));
	assign status.sweep_last = &sweep_q;
	assign status.out_free   = !out_valid_q | out_ready;

	assign out_valid = out_valid_q;
	assign out_was   = out_was_q;
	assign out_count = out_cnt_q;

endmodule

>>> rtl/core/bloom_filter_mark_test.sv
// Top level of the bloom filter mark/test block: controller plus datapath.
// Depends on bfmt_pkg, bfmt_ctrl, bfmt_dp (which holds bfmt_ram).
//
//  channel   dir  signals                          contents
//  s_axis    in   tvalid tready tdata[63:0] tuser  block_number; action
//  m_axis    out  tvalid tready tdata[39:0]        was_marked, mark_count
//  cfg       in   cfg_we cfg_wdata[4:0]            size_shift
//
// Test/mark: five multiplies on one shared 32x32 multiplier, one finish step, then
// six probes, each in S_RD then S_WR, since every probe reads one row of the
// single-port filter RAM and, on a mark, rewrites it.
// Clear: one RAM row zeroed per cycle, over all 2^(MAX_SIZE_SHIFT-6) rows.
// After reset the same sweep runs before s_axis_tready rises.
// The result sits in an output register; a stalled m_axis holds the next result.
module bloom_filter_mark_test import bfmt_pkg::*; #(
	parameter int MAX_SIZE_SHIFT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,	// [63:0] block_number
	input  logic [1:0]  s_axis_tuser,	// [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,	// [0] was_marked, [32:1] mark_count, [39:33] zero
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	cmd_t        cmd;
	status_t     status;
	logic        out_was;
	logic [31:0] out_count;

	bfmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.status    (status),
		.cmd       (cmd)
	);

	bfmt_dp #(
		.MAX_SIZE_SHIFT (MAX_SIZE_SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_action (s_axis_tuser),
		.in_block  (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_was   (out_was),
		.out_count (out_count)
	);

	assign s_axis_tready = cmd.ready;
	assign m_axis_tdata  = {7'd0, out_count, out_was};

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second transfer accepted while an item is in flight");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !s_axis_tready)
		else $error("input ready during clear sweep");

	a_load_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.mul_en || cmd.sweep)
		else $error("accepted item did not start hashing or clearing");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_axis_tvalid)
		else $error("result not presented after emit");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul_en, cmd.set_h2, cmd.probe_wr, cmd.sweep, cmd.emit}))
		else $error("conflicting datapath commands");

endmodule
